// File: rtl/smf_pkg.sv
// Shared types and constants for the substring match finder.
// Used by the channel interfaces, the window cell and the top level; no dependencies.
package smf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned LEN_W      = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = 4'd1;

  // Per-cycle control broadcast to every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: rtl/smf_if.sv
// Valid/ready channel interfaces for the text input and the match output.
// Depends on smf_pkg for the byte width.
interface smf_in_if;
  logic                         valid;
  logic                         ready;
  logic [smf_pkg::BYTE_W-1:0]   text_byte;
  logic                         is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface smf_out_if #(
  parameter int unsigned POS_W = 13
);
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] match_position;

  modport source (output valid, output match_position, input ready);
  modport sink   (input valid, input match_position, output ready);
endinterface

// File: rtl/substring_match_finder.sv
// Top level of the streaming substring match finder.
// Depends on smf_pkg, smf_in_if / smf_out_if and smf_cell.

// The block takes one text byte per cycle and reports the 1-based start
// position of every full match of the configured pattern (1 to PATTERN_MAX
// bytes, overlapping matches included), registered when the matching byte
// is transferred. Throughput is one byte per clock: the match decision is a
// parallel byte compare across the row of window cells feeding one AND, and
// the result lands in an output register backed by one skid entry, so input
// keeps flowing while a match waits to be taken; input stalls only when both
// entries are full. A byte flagged is_last is searched like any other and then
// clears the window and the position counter. Once TEXT_MAX bytes of one text
// have been taken, further bytes are consumed without being counted or
// searched until the last byte. A pattern_length of zero acts as one and one
// above PATTERN_MAX acts as PATTERN_MAX. Configuration must be written while
// the block is idle; the block itself does not enforce it. No reset sweep.
module substring_match_finder #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned TEXT_MAX    = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  smf_in_if.sink                            in_chan,
  smf_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [smf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned CNT_W = $clog2(TEXT_MAX + 1);
  localparam int unsigned BW    = smf_pkg::BYTE_W;
  localparam int unsigned SEL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Configuration registers.
  logic [smf_pkg::CFG_DATA_W-1:0] pattern_r;
  logic [smf_pkg::LEN_W-1:0]      length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= smf_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        smf_pkg::CFG_PATTERN_BYTES:  pattern_r <= cfg_data;
        smf_pkg::CFG_PATTERN_LENGTH: length_r  <= cfg_data[smf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length into the supported range.
  logic [smf_pkg::LEN_W-1:0] len_eff;

  always_comb begin
    len_eff = length_r;
    if (length_r == '0) begin
      len_eff = smf_pkg::LEN_RESET;
    end else if (length_r > smf_pkg::LEN_W'(PATTERN_MAX)) begin
      len_eff = smf_pkg::LEN_W'(PATTERN_MAX);
    end
  end

  // Handshake and per-text byte counter.
  logic             fire;
  logic [CNT_W-1:0] seen_r;
  logic [CNT_W-1:0] seen_nxt;
  logic [CNT_W-1:0] seen_inc;
  logic             below_max;
  logic             skid_valid_r;

  assign in_chan.ready = !skid_valid_r;
  assign fire          = in_chan.valid && in_chan.ready;
  assign below_max     = seen_r < CNT_W'(TEXT_MAX);
  assign seen_inc      = seen_r + CNT_W'(1);

  always_comb begin
    seen_nxt = seen_r;
    if (fire) begin
      if (in_chan.is_last) begin
        seen_nxt = '0;
      end else if (below_max) begin
        seen_nxt = seen_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  // Row of window cells. Cell j takes in the byte taken j transfers ago and
  // checks it against pattern byte len-1-j; cells at or beyond the length
  // are don't-care.
  smf_pkg::cell_ctrl_t   cell_ctrl;
  logic [BW-1:0]         win      [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_ok;

  assign cell_ctrl.shift = fire && below_max;
  assign cell_ctrl.clear = fire && in_chan.is_last;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [BW-1:0]             cin;
    logic [BW-1:0]             want;
    logic                      care;
    logic [smf_pkg::LEN_W-1:0] idx;

    if (j == 0) begin : g_head
      assign cin = in_chan.text_byte;
    end else begin : g_body
      assign cin = win[j-1];
    end

    assign care = smf_pkg::LEN_W'(j) < len_eff;
    assign idx  = len_eff - smf_pkg::LEN_W'(1) - smf_pkg::LEN_W'(j);
    assign want = pattern_r[idx[SEL_W-1:0]*BW +: BW];

    smf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .data_in  (cin),
      .want     (want),
      .care     (care),
      .data_out (win[j]),
      .ok       (cell_ok[j])
    );
  end

  // Match decision and start position for the byte being transferred.
  logic             hit;
  logic [CNT_W-1:0] hit_pos;

  assign hit     = cell_ctrl.shift && (seen_inc >= CNT_W'(len_eff)) && (&cell_ok);
  assign hit_pos = seen_inc - CNT_W'(len_eff) + CNT_W'(1);

  // Output register with one skid entry behind it.
  logic             out_valid_r;
  logic [CNT_W-1:0] out_pos_r;
  logic [CNT_W-1:0] skid_pos_r;
  logic             pop;

  assign pop = out_valid_r && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // Input is stalled here, so no new match can arrive.
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (hit) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_pos_r <= skid_pos_r;
      end
    end else if (hit) begin
      if (!out_valid_r || pop) begin
        out_pos_r <= hit_pos;
      end else begin
        skid_pos_r <= hit_pos;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.match_position = out_pos_r;

endmodule

// File: rtl/smf_cell.sv
// One window cell: holds a text byte, passes it to its neighbor on a shift
// and compares the incoming byte with its pattern byte. Depends on smf_pkg.
module smf_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  smf_pkg::cell_ctrl_t         ctrl,
  input  logic [smf_pkg::BYTE_W-1:0]  data_in,
  input  logic [smf_pkg::BYTE_W-1:0]  want,
  input  logic                        care,
  output logic [smf_pkg::BYTE_W-1:0]  data_out,
  output logic                        ok
);

  logic [smf_pkg::BYTE_W-1:0] byte_r;
  logic [smf_pkg::BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = '0;
    end else if (ctrl.shift) begin
      byte_nxt = data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // The compare looks at the byte this cell takes in on the current shift.
  assign ok       = !care || (data_in == want);
  assign data_out = byte_r;

endmodule
